[hw/rtl/hsv_hue_saturation_adjust_core_macros.svh]
// assertion macros for the hue and saturation adjust core
`ifndef HSV_HUE_SATURATION_ADJUST_CORE_MACROS_SVH
`define HSV_HUE_SATURATION_ADJUST_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define HSV_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hsv adjust: forbidden condition");

`define HSV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsv adjust: expected condition missing");

`else

`define HSV_ASSERT_NEVER(label, cond)

`define HSV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hw/rtl/hsvadj_pkg.sv]
// shared constants and types for the hue and saturation adjust core
package hsvadj_pkg;

    localparam int FRAC_BITS = 8;
    localparam int HUE_W     = 11;
    localparam int SAT_W     = 10;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    typedef logic [HUE_W-1:0] hue_t;
    typedef logic [SAT_W-1:0] sat_t;

    localparam hue_t HUE_TURN  = 11'd1536;
    localparam hue_t HUE_RESET = 11'd0;
    localparam sat_t SAT_RESET = 10'd256;

    localparam logic REG_HUE_SHIFT = 1'b0;
    localparam logic REG_SAT_RATIO = 1'b1;

    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;
    localparam logic [2:0] SEC_MR = 3'd5;

endpackage

[hw/rtl/hsv_hue_saturation_adjust_core.sv]
// hue rotation and saturation scaling of an rgb pixel stream
//
// input channel: in_valid / in_stall with red_in, green_in, blue_in, frame_end_in
// output channel: out_valid / out_stall with red_out, green_out, blue_out, frame_end_out
// a transfer happens at a clock edge with valid high and stall low
// registers on the apb port: hue_shift at 0x0, saturation_ratio at 0x4
// write registers only while no pixel is in flight
// throughput: one pixel per cycle while in_stall is low, set by a fully pipelined datapath with
// one restoring divider step per stage for the two hue interpolation terms
// a stalled output is held in the output register, and one more pixel
// drains into a skid register; in_stall rises only when that skid is full
// frame_end_in travels with its pixel and comes out unchanged
// reset empties the pipeline and sets hue_shift to 0, saturation_ratio to 256
module hsv_hue_saturation_adjust_core #(
    parameter int COLOR_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hsvadj_pkg::ADDR_W-1:0] paddr,
    input  logic [hsvadj_pkg::DATA_W-1:0] pwdata,
    output logic [hsvadj_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [COLOR_BITS-1:0]         red_in,
    input  logic [COLOR_BITS-1:0]         green_in,
    input  logic [COLOR_BITS-1:0]         blue_in,
    input  logic                          frame_end_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COLOR_BITS-1:0]         red_out,
    output logic [COLOR_BITS-1:0]         green_out,
    output logic [COLOR_BITS-1:0]         blue_out,
    output logic                          frame_end_out
);
    import hsvadj_pkg::*;

`include "hsv_hue_saturation_adjust_core_macros.svh"

    localparam int CB     = COLOR_BITS;
    localparam int HSIX_W = CB + 3;
    localparam int H_W    = CB + 12;
    localparam int HW_W   = CB + 11;
    localparam int DRAW_W = CB + SAT_W;
    localparam int D_W    = CB + FRAC_BITS;
    localparam int FR_W   = CB + FRAC_BITS;
    localparam int N_W    = 2 * CB + 2 * FRAC_BITS;
    localparam int A_W    = 2 * CB + 1;
    localparam int NP     = CB + 6;

    typedef struct packed {
        logic          grey;
        logic          fe;
        logic [2:0]    sector;
        logic [CB-1:0] mx;
        logic [CB-1:0] delta;
        logic [CB-1:0] p;
    } side_t;

    // configuration
    hue_t hue_shift_reg;
    sat_t sat_ratio_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_shift_reg <= HUE_RESET;
            sat_ratio_reg <= SAT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_HUE_SHIFT: hue_shift_reg <= pwdata[HUE_W-1:0];
                REG_SAT_RATIO: sat_ratio_reg <= pwdata[SAT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_HUE_SHIFT: prdata = DATA_W'(hue_shift_reg);
            REG_SAT_RATIO: prdata = DATA_W'(sat_ratio_reg);
            default:       prdata = '0;
        endcase
    end

    // pipeline control
    logic          adv;
    logic [NP-1:0] v_reg;
    logic [NP-1:0] v_next;
    logic          skid_v_reg;
    logic          out_v_reg;

    assign adv      = !skid_v_reg;
    assign in_stall = skid_v_reg;

    always_comb
    begin
        v_next = {v_reg[NP-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= v_next;
    end

    // stage 1: max, min, chroma, hue in sixths scaled by delta
    logic [CB-1:0]     mx_c, mn_c, delta_c;
    logic [HSIX_W-1:0] hsix_c, dx_c;
    logic [CB-1:0]     s1_mx_reg, s1_delta_reg;
    logic [HSIX_W-1:0] s1_hsix_reg;
    logic              s1_grey_reg, s1_fe_reg;

    always_comb
    begin
        if (red_in >= green_in && red_in >= blue_in)
            mx_c = red_in;
        else if (green_in >= blue_in)
            mx_c = green_in;
        else
            mx_c = blue_in;
        if (red_in <= green_in && red_in <= blue_in)
            mn_c = red_in;
        else if (green_in <= blue_in)
            mn_c = green_in;
        else
            mn_c = blue_in;
        delta_c = mx_c - mn_c;
        dx_c    = HSIX_W'(delta_c);
        if (red_in == mx_c)
        begin
            if (green_in >= blue_in)
                hsix_c = HSIX_W'(green_in) - HSIX_W'(blue_in);
            else
                hsix_c = (dx_c << 2) + (dx_c << 1) - HSIX_W'(blue_in) + HSIX_W'(green_in);
        end
        else if (green_in == mx_c)
            hsix_c = (dx_c << 1) + HSIX_W'(blue_in) - HSIX_W'(red_in);
        else
            hsix_c = (dx_c << 2) + HSIX_W'(red_in) - HSIX_W'(green_in);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mx_reg    <= mx_c;
            s1_delta_reg <= delta_c;
            s1_hsix_reg  <= hsix_c;
            s1_grey_reg  <= (delta_c == '0);
            s1_fe_reg    <= frame_end_in;
        end
    end

    // stage 2: hue shift and saturation products
    hue_t             sh_eff;
    logic [H_W-1:0]   s2_h_reg;
    logic [DRAW_W-1:0] s2_d_reg;
    logic [CB-1:0]    s2_mx_reg, s2_delta_reg;
    logic             s2_grey_reg, s2_fe_reg;

    assign sh_eff = (hue_shift_reg >= HUE_TURN) ? hue_shift_reg - HUE_TURN : hue_shift_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_h_reg     <= H_W'({s1_hsix_reg, {FRAC_BITS{1'b0}}})
                            + H_W'(sh_eff) * H_W'(s1_delta_reg);
            s2_d_reg     <= DRAW_W'(s1_delta_reg) * DRAW_W'(sat_ratio_reg);
            s2_mx_reg    <= s1_mx_reg;
            s2_delta_reg <= s1_delta_reg;
            s2_grey_reg  <= s1_grey_reg;
            s2_fe_reg    <= s1_fe_reg;
        end
    end

    // stage 3: hue wrap and saturation clamp
    logic [H_W-1:0]  turn_c;
    logic [H_W-1:0]  hwrap_c;
    logic [D_W-1:0]  cap_c;
    logic [HW_W-1:0] s3_h_reg;
    logic [D_W-1:0]  s3_d_reg;
    logic [CB-1:0]   s3_mx_reg, s3_delta_reg;
    logic            s3_grey_reg, s3_fe_reg;

    always_comb
    begin
        turn_c  = (H_W'(s2_delta_reg) << 10) + (H_W'(s2_delta_reg) << 9);
        hwrap_c = (s2_h_reg >= turn_c) ? s2_h_reg - turn_c : s2_h_reg;
        cap_c   = {s2_mx_reg, {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_h_reg     <= hwrap_c[HW_W-1:0];
            s3_d_reg     <= (s2_d_reg > DRAW_W'(cap_c)) ? cap_c : s2_d_reg[D_W-1:0];
            s3_mx_reg    <= s2_mx_reg;
            s3_delta_reg <= s2_delta_reg;
            s3_grey_reg  <= s2_grey_reg;
            s3_fe_reg    <= s2_fe_reg;
        end
    end

    // stage 4: sector, fraction and the p term
    logic [HW_W-1:0] den_c;
    logic [HW_W-1:0] base_c;
    logic [2:0]      sec_c;
    logic [5:1]      ge_c;
    logic [FR_W-1:0] fr_c;
    logic [D_W:0]    dup_c;
    side_t           s4_side_reg;
    logic [D_W-1:0]  s4_d_reg;
    logic [FR_W-1:0] s4_fr_reg, s4_frc_reg;

    always_comb
    begin
        den_c = HW_W'({s3_delta_reg, {FRAC_BITS{1'b0}}});
        for (int k = 1; k <= 5; k++)
            ge_c[k] = (s3_h_reg >= den_c * HW_W'(k));
        if (ge_c[5])
            sec_c = SEC_MR;
        else if (ge_c[4])
            sec_c = SEC_BM;
        else if (ge_c[3])
            sec_c = SEC_CB;
        else if (ge_c[2])
            sec_c = SEC_GC;
        else if (ge_c[1])
            sec_c = SEC_YG;
        else
            sec_c = SEC_RY;
        base_c = den_c * HW_W'(sec_c);
        fr_c   = FR_W'(s3_h_reg - base_c);
        dup_c  = {1'b0, s3_d_reg} + (D_W + 1)'({FRAC_BITS{1'b1}});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_side_reg.grey   <= s3_grey_reg;
            s4_side_reg.fe     <= s3_fe_reg;
            s4_side_reg.sector <= sec_c;
            s4_side_reg.mx     <= s3_mx_reg;
            s4_side_reg.delta  <= s3_delta_reg;
            s4_side_reg.p      <= s3_mx_reg - dup_c[CB+FRAC_BITS-1:FRAC_BITS];
            s4_d_reg           <= s3_d_reg;
            s4_fr_reg          <= fr_c;
            s4_frc_reg         <= FR_W'(den_c) - fr_c;
        end
    end

    // stage 5: interpolation numerators
    side_t          s5_side_reg;
    logic [N_W-1:0] s5_nq_reg, s5_nt_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_side_reg <= s4_side_reg;
            s5_nq_reg   <= N_W'(s4_d_reg) * N_W'(s4_fr_reg);
            s5_nt_reg   <= N_W'(s4_d_reg) * N_W'(s4_frc_reg);
        end
    end

    // stage 6 and divider stages: ceiling quotient by delta, one bit per stage
    logic [N_W:0]   rq_c, rt_c;
    side_t          dside_reg [0:CB];
    logic [A_W-1:0] drq_reg [0:CB];
    logic [A_W-1:0] drt_reg [0:CB];
    logic [CB-1:0]  dqq_reg [0:CB];
    logic [CB-1:0]  dqt_reg [0:CB];
    logic [A_W-1:0] drq_next [0:CB-1];
    logic [A_W-1:0] drt_next [0:CB-1];
    logic [CB-1:0]  dqq_next [0:CB-1];
    logic [CB-1:0]  dqt_next [0:CB-1];
    logic [A_W-1:0] trial_c [0:CB-1];

    always_comb
    begin
        rq_c = {1'b0, s5_nq_reg} + (N_W + 1)'({2 * FRAC_BITS{1'b1}});
        rt_c = {1'b0, s5_nt_reg} + (N_W + 1)'({2 * FRAC_BITS{1'b1}});
    end

    always_comb
    begin
        for (int j = 0; j < CB; j++)
        begin
            trial_c[j]  = A_W'(dside_reg[j].delta) << (CB - 1 - j);
            drq_next[j] = drq_reg[j];
            drt_next[j] = drt_reg[j];
            dqq_next[j] = dqq_reg[j];
            dqt_next[j] = dqt_reg[j];
            if (drq_reg[j] >= trial_c[j])
            begin
                drq_next[j]           = drq_reg[j] - trial_c[j];
                dqq_next[j][CB-1-j]   = 1'b1;
            end
            if (drt_reg[j] >= trial_c[j])
            begin
                drt_next[j]           = drt_reg[j] - trial_c[j];
                dqt_next[j][CB-1-j]   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dside_reg[0] <= s5_side_reg;
            drq_reg[0]   <= rq_c[N_W:2*FRAC_BITS] + A_W'(s5_side_reg.delta) - A_W'(1);
            drt_reg[0]   <= rt_c[N_W:2*FRAC_BITS] + A_W'(s5_side_reg.delta) - A_W'(1);
            dqq_reg[0]   <= '0;
            dqt_reg[0]   <= '0;
            for (int j = 0; j < CB; j++)
            begin
                dside_reg[j+1] <= dside_reg[j];
                drq_reg[j+1]   <= drq_next[j];
                drt_reg[j+1]   <= drt_next[j];
                dqq_reg[j+1]   <= dqq_next[j];
                dqt_reg[j+1]   <= dqt_next[j];
            end
        end
    end

    // final select
    side_t         fs;
    logic [CB-1:0] qv_c, tv_c;
    logic [CB-1:0] sel_r, sel_g, sel_b;

    always_comb
    begin
        fs   = dside_reg[CB];
        qv_c = fs.mx - dqq_reg[CB];
        tv_c = fs.mx - dqt_reg[CB];
        case (fs.sector)
            SEC_RY:  begin sel_r = fs.mx; sel_g = tv_c;  sel_b = fs.p;  end
            SEC_YG:  begin sel_r = qv_c;  sel_g = fs.mx; sel_b = fs.p;  end
            SEC_GC:  begin sel_r = fs.p;  sel_g = fs.mx; sel_b = tv_c;  end
            SEC_CB:  begin sel_r = fs.p;  sel_g = qv_c;  sel_b = fs.mx; end
            SEC_BM:  begin sel_r = tv_c;  sel_g = fs.p;  sel_b = fs.mx; end
            default: begin sel_r = fs.mx; sel_g = fs.p;  sel_b = qv_c;  end
        endcase
        if (fs.grey)
        begin
            sel_r = fs.mx;
            sel_g = fs.mx;
            sel_b = fs.mx;
        end
    end

    // output register and skid
    logic          out_free;
    logic          last_v;
    logic [CB-1:0] out_r_reg, out_g_reg, out_b_reg;
    logic          out_fe_reg;
    logic [CB-1:0] skid_r_reg, skid_g_reg, skid_b_reg;
    logic          skid_fe_reg;

    assign out_free = !out_v_reg || !out_stall;
    assign last_v   = v_reg[NP-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_v_reg  <= skid_v_reg || last_v;
            skid_v_reg <= 1'b0;
        end
        else if (adv && last_v)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_r_reg  <= skid_r_reg;
                out_g_reg  <= skid_g_reg;
                out_b_reg  <= skid_b_reg;
                out_fe_reg <= skid_fe_reg;
            end
            else
            begin
                out_r_reg  <= sel_r;
                out_g_reg  <= sel_g;
                out_b_reg  <= sel_b;
                out_fe_reg <= fs.fe;
            end
        end
        else if (adv && last_v)
        begin
            skid_r_reg  <= sel_r;
            skid_g_reg  <= sel_g;
            skid_b_reg  <= sel_b;
            skid_fe_reg <= fs.fe;
        end
    end

    assign out_valid     = out_v_reg;
    assign red_out       = out_r_reg;
    assign green_out     = out_g_reg;
    assign blue_out      = out_b_reg;
    assign frame_end_out = out_fe_reg;

    `HSV_ASSERT_NEVER(a_skid_needs_out, skid_v_reg && !out_v_reg)
    `HSV_ASSERT_NEXT(a_skid_drains, skid_v_reg && !out_stall, out_v_reg && !skid_v_reg)
    `HSV_ASSERT_NEVER(a_sector_range, last_v && !fs.grey && fs.sector > SEC_MR)

endmodule
